// ----- design/nqb_pkg.sv -----
package nqb_pkg;

    // default largest board
    localparam int MAX_N_DEF = 16;

    // microprogram step addresses
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_TEST,
        S_BACKCHK,
        S_BACK,
        S_FAIL,
        S_EMPTY,
        S_RDK,
        S_ROW,
        S_NEXTK
    } step_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_TRY,
        OP_BACK,
        OP_EMIT_STAT,
        OP_EMIT_ROW
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_IN_ACC,
        C_N_ZERO,
        C_ROW_FULL,
        C_EXHAUST,
        C_ROW_ZERO,
        C_OUT_FREE,
        C_K_DONE
    } cond_t;

    // one control word: operation, jump condition, taken and fall-through targets, solved flag
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jmp;
        step_t nxt;
        logic  sol;
    } uword_t;

    // control store
    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        begin
            case (s)
                S_IDLE:    w = '{OP_LOAD,      C_IN_ACC,   S_START, S_IDLE,    1'b0};
                S_START:   w = '{OP_NOP,       C_N_ZERO,   S_EMPTY, S_SEARCH,  1'b0};
                S_SEARCH:  w = '{OP_NOP,       C_ROW_FULL, S_RDK,   S_TEST,    1'b0};
                S_TEST:    w = '{OP_TRY,       C_EXHAUST,  S_BACKCHK, S_SEARCH, 1'b0};
                S_BACKCHK: w = '{OP_NOP,       C_ROW_ZERO, S_FAIL,  S_BACK,    1'b0};
                S_BACK:    w = '{OP_BACK,      C_NEVER,    S_IDLE,  S_SEARCH,  1'b0};
                S_FAIL:    w = '{OP_EMIT_STAT, C_OUT_FREE, S_IDLE,  S_FAIL,    1'b0};
                S_EMPTY:   w = '{OP_EMIT_STAT, C_OUT_FREE, S_IDLE,  S_EMPTY,   1'b1};
                S_RDK:     w = '{OP_NOP,       C_NEVER,    S_IDLE,  S_ROW,     1'b1};
                S_ROW:     w = '{OP_EMIT_ROW,  C_OUT_FREE, S_NEXTK, S_ROW,     1'b1};
                S_NEXTK:   w = '{OP_NOP,       C_K_DONE,   S_IDLE,  S_RDK,     1'b1};
                default:   w = '{OP_NOP,       C_NEVER,    S_IDLE,  S_IDLE,    1'b0};
            endcase
            return w;
        end
    endfunction

endpackage

// ----- design/n_queens_backtrack_solver.sv -----
// N-queens solver: one input word gives the board size (values above MAX_N saturate to
// MAX_N), and the block runs a depth-first search that places one queen per row, trying
// columns in ascending order, and returns the first full placement as one output word per
// row, the final one marked with last. Sizes two and three give a single word with
// solved = 0, and size zero a single word with solved = 1 and has_row = 0. The search is
// driven by a small microprogram that tests one candidate column per pass through its
// search and test steps; running out of columns in a row backs up through a check step and
// a back step, and each row word is read out through read, emit and next-row steps. The
// per-row column stack is a small memory with a registered read port. A new size is taken
// only when the sequencer is idle, while the last output word may still be waiting.
module n_queens_backtrack_solver #(
    parameter int MAX_N = nqb_pkg::MAX_N_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [4:0] board_size,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       solved,
    output logic       has_row,
    output logic [3:0] row_index,
    output logic [3:0] queen_column,
    output logic       last,
    output logic       out_valid,
    input  logic       out_ready
);
    import nqb_pkg::*;

    localparam int RW  = $clog2(MAX_N + 1);
    localparam int AW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int DN  = 2 * MAX_N - 1;
    localparam int DIW = $clog2(2 * MAX_N);

    step_t           step_reg, step_next;
    logic [RW-1:0]   n_reg, n_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [RW-1:0]   cand_reg, cand_next;
    logic [RW-1:0]   k_reg, k_next;
    logic [MAX_N-1:0] cols_reg, cols_next;
    logic [DN-1:0]   dn_reg, dn_next;
    logic [DN-1:0]   up_reg, up_next;
    logic            out_valid_reg, out_valid_next;
    logic            solved_reg, has_row_reg, last_reg;
    logic [3:0]      row_index_reg, queen_column_reg;

    logic [AW-1:0]   stack [MAX_N];
    logic [AW-1:0]   rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            stk_we;

    uword_t          uw;
    logic            cond_hit;
    logic            in_acc;
    logic            out_free;
    logic            emit_load;
    logic            exhaust;
    logic            is_free;
    logic [RW-1:0]   row_m1;
    logic            tg_en;
    logic [RW-1:0]   tg_row;
    logic [AW-1:0]   tg_col;
    logic [DIW-1:0]  dn_idx, up_idx, tdn_idx, tup_idx;

    // control word fetch and handshake terms
    assign uw        = ucode_rom(step_reg);
    assign in_ready  = (uw.op == OP_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_load = ((uw.op == OP_EMIT_STAT) || (uw.op == OP_EMIT_ROW)) && out_free;
    assign exhaust   = (cand_reg == n_reg);
    assign row_m1    = row_reg - 1'b1;

    // attack test for the current row and candidate column
    assign dn_idx  = DIW'(row_reg) + DIW'(MAX_N - 1) - DIW'(cand_reg);
    assign up_idx  = DIW'(row_reg) + DIW'(cand_reg);
    assign is_free = !cols_reg[cand_reg[AW-1:0]] && !dn_reg[dn_idx] && !up_reg[up_idx];

    // jump condition
    always_comb
    begin
        case (uw.cond)
            C_NEVER:    cond_hit = 1'b0;
            C_IN_ACC:   cond_hit = in_acc;
            C_N_ZERO:   cond_hit = (n_reg == '0);
            C_ROW_FULL: cond_hit = (row_reg == n_reg);
            C_EXHAUST:  cond_hit = exhaust;
            C_ROW_ZERO: cond_hit = (row_reg == '0);
            C_OUT_FREE: cond_hit = out_free;
            C_K_DONE:   cond_hit = (k_reg == n_reg);
            default:    cond_hit = 1'b0;
        endcase
    end

    // stack read address
    always_comb
    begin
        case (step_reg)
            S_BACKCHK: rd_addr = row_m1[AW-1:0];
            default:   rd_addr = k_reg[AW-1:0];
        endcase
    end

    // datapath and sequencer next state
    always_comb
    begin
        step_next      = cond_hit ? uw.jmp : uw.nxt;
        n_next         = n_reg;
        row_next       = row_reg;
        cand_next      = cand_reg;
        k_next         = k_reg;
        cols_next      = cols_reg;
        dn_next        = dn_reg;
        up_next        = up_reg;
        stk_we         = 1'b0;
        tg_en          = 1'b0;
        tg_row         = row_reg;
        tg_col         = cand_reg[AW-1:0];
        out_valid_next = emit_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        case (uw.op)
            OP_LOAD:
            begin
                if (in_acc)
                begin
                    if ({1'b0, board_size} > 6'(MAX_N))
                        n_next = RW'(MAX_N);
                    else
                        n_next = RW'(board_size);
                    row_next  = '0;
                    cand_next = '0;
                    k_next    = '0;
                    cols_next = '0;
                    dn_next   = '0;
                    up_next   = '0;
                end
            end
            OP_TRY:
            begin
                if (!exhaust)
                begin
                    if (is_free)
                    begin
                        stk_we    = 1'b1;
                        tg_en     = 1'b1;
                        row_next  = row_reg + 1'b1;
                        cand_next = '0;
                    end
                    else
                    begin
                        cand_next = cand_reg + 1'b1;
                    end
                end
            end
            OP_BACK:
            begin
                tg_en     = 1'b1;
                tg_row    = row_m1;
                tg_col    = rd_data_reg;
                row_next  = row_m1;
                cand_next = RW'(rd_data_reg) + 1'b1;
            end
            OP_EMIT_ROW:
            begin
                if (out_free)
                    k_next = k_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        tdn_idx = DIW'(tg_row) + DIW'(MAX_N - 1) - DIW'(tg_col);
        tup_idx = DIW'(tg_row) + DIW'(tg_col);
        // place or lift a queen
        if (tg_en)
        begin
            cols_next[tg_col] = ~cols_reg[tg_col];
            dn_next[tdn_idx]  = ~dn_reg[tdn_idx];
            up_next[tup_idx]  = ~up_reg[tup_idx];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            n_reg         <= '0;
            row_reg       <= '0;
            cand_reg      <= '0;
            k_reg         <= '0;
            cols_reg      <= '0;
            dn_reg        <= '0;
            up_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            n_reg         <= n_next;
            row_reg       <= row_next;
            cand_reg      <= cand_next;
            k_reg         <= k_next;
            cols_reg      <= cols_next;
            dn_reg        <= dn_next;
            up_reg        <= up_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // column stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack[row_reg[AW-1:0]] <= cand_reg[AW-1:0];
        rd_data_reg <= stack[rd_addr];
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            solved_reg       <= uw.sol;
            has_row_reg      <= (uw.op == OP_EMIT_ROW);
            row_index_reg    <= (uw.op == OP_EMIT_ROW) ? 4'(k_reg) : 4'd0;
            queen_column_reg <= (uw.op == OP_EMIT_ROW) ? 4'(rd_data_reg) : 4'd0;
            last_reg         <= (uw.op == OP_EMIT_STAT) || (RW'(k_reg + 1'b1) == n_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign solved       = solved_reg;
    assign has_row      = has_row_reg;
    assign row_index    = row_index_reg;
    assign queen_column = queen_column_reg;
    assign last         = last_reg;

    // one queen per placed row in every attack mask
    a_cols_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cols_reg) == int'(row_reg))
        else $error("column mask does not match placed rows");

    a_dn_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(dn_reg) == int'(row_reg))
        else $error("down diagonal mask does not match placed rows");

    a_up_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(up_reg) == int'(row_reg))
        else $error("up diagonal mask does not match placed rows");

    // a row word always belongs to a solved run
    a_row_solved: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_row |-> solved)
        else $error("row word without a solution");

endmodule

// ----- bench/n_queens_placement_checker.sv -----
`timescale 1ns / 1ps

module n_queens_placement_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [4:0] board_size,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       solved,
    input  logic       has_row,
    input  logic [3:0] row_index,
    input  logic [3:0] queen_column,
    input  logic       last,
    input  logic       out_valid,
    input  logic       out_ready,
    output int         mismatches,
    output int         words_owed,
    output int         boards_taken,
    output int         boards_solved,
    output int         words_taken
);

    localparam int BOARD_MAX = nqb_pkg::MAX_N_DEF;

    // one output word as the block presents it
    typedef struct packed {
        logic       solved;
        logic       has_row;
        logic [3:0] row_index;
        logic [3:0] queen_column;
        logic       last;
    } row_word_t;

    row_word_t                   owed_q [$];
    row_word_t                   want;
    row_word_t                   got;
    logic [4*BOARD_MAX-1:0]      placement;
    int                          size_now;

    // depth-first search, first placement found, one 4-bit column per row
    function automatic bit find_placement(input int n, output logic [4*BOARD_MAX-1:0] cols);
        logic [BOARD_MAX-1:0]   col_busy;
        logic [2*BOARD_MAX-2:0] down_busy;
        logic [2*BOARD_MAX-2:0] up_busy;
        int                     row;
        int                     col;
        bit                     found;
        begin
            cols      = '0;
            col_busy  = '0;
            down_busy = '0;
            up_busy   = '0;
            row       = 0;
            col       = 0;
            found     = 1'b1;
            while (row < n && found) begin
                // skip attacked columns
                while (col < n && (col_busy[col] || down_busy[row + BOARD_MAX - 1 - col]
                                   || up_busy[row + col]))
                    col++;
                if (col < n) begin
                    cols[4*row +: 4]                   = col[3:0];
                    col_busy[col]                      = 1'b1;
                    down_busy[row + BOARD_MAX - 1 - col] = 1'b1;
                    up_busy[row + col]                 = 1'b1;
                    row++;
                    col = 0;
                end
                else if (row == 0) begin
                    found = 1'b0;
                end
                else begin
                    // back up one row, lift its queen, resume at the next column
                    row--;
                    col                                = int'(cols[4*row +: 4]);
                    col_busy[col]                      = 1'b0;
                    down_busy[row + BOARD_MAX - 1 - col] = 1'b0;
                    up_busy[row + col]                 = 1'b0;
                    col++;
                end
            end
            return found;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            // accepted board size: queue every word it owes
            if (in_valid && in_ready) begin
                size_now = (int'(board_size) > BOARD_MAX) ? BOARD_MAX : int'(board_size);
                boards_taken++;
                if (size_now == 0) begin
                    owed_q.push_back('{1'b1, 1'b0, 4'd0, 4'd0, 1'b1});
                    boards_solved++;
                end
                else if (!find_placement(size_now, placement)) begin
                    owed_q.push_back('{1'b0, 1'b0, 4'd0, 4'd0, 1'b1});
                end
                else begin
                    boards_solved++;
                    for (int k = 0; k < size_now; k++)
                        owed_q.push_back('{1'b1, 1'b1, k[3:0], placement[4*k +: 4],
                                           (k == size_now - 1)});
                end
            end

            // accepted word: compare with the oldest one owed
            if (out_valid && out_ready) begin
                got = '{solved, has_row, row_index, queen_column, last};
                words_taken++;
                if (owed_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word solved=%0d has_row=%0d row=%0d %s",
                                 $realtime, got.solved, got.has_row, got.row_index,
                                 $sformatf("col=%0d last=%0d", got.queen_column, got.last));
                end
                else begin
                    want = owed_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: word mismatch expected solved=%0d has_row=%0d %s",
                                     $realtime, want.solved, want.has_row,
                                     $sformatf("row=%0d col=%0d last=%0d", want.row_index,
                                               want.queen_column, want.last));
                            $display("%0t: word mismatch got solved=%0d has_row=%0d %s",
                                     $realtime, got.solved, got.has_row,
                                     $sformatf("row=%0d col=%0d last=%0d", got.row_index,
                                               got.queen_column, got.last));
                        end
                    end
                end
            end

            words_owed = owed_q.size();
        end
    end

endmodule

// ----- bench/n_queens_backtrack_solver_tb.sv -----
`timescale 1ns / 1ps

module n_queens_backtrack_solver_tb;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic [4:0] board_size   = 5'd0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic       solved;
    logic       has_row;
    logic [3:0] row_index;
    logic [3:0] queen_column;
    logic       last;
    logic       out_valid;
    logic       out_ready    = 1'b0;

    int mismatches;
    int words_owed;
    int boards_taken;
    int boards_solved;
    int words_taken;

    // idle percentages for each side, and the long output hold-off
    int send_idle  = 38;
    int recv_idle  = 48;
    bit hold_go    = 1'b0;
    bit hold_done  = 1'b0;
    int hold_left  = 0;
    int pick;

    n_queens_backtrack_solver DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .board_size   (board_size),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .solved       (solved),
        .has_row      (has_row),
        .row_index    (row_index),
        .queen_column (queen_column),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

    n_queens_placement_checker placement_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .board_size    (board_size),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .solved        (solved),
        .has_row       (has_row),
        .row_index     (row_index),
        .queen_column  (queen_column),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mismatches    (mismatches),
        .words_owed    (words_owed),
        .boards_taken  (boards_taken),
        .boards_solved (boards_solved),
        .words_taken   (words_taken)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // output side: random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // offer one board size and hold it until accepted
    task automatic send_size(input logic [4:0] n);
        begin
            while ($urandom_range(99) < send_idle) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            board_size <= n;
            in_valid   <= 1'b1;
            do
                @(posedge clk);
            while (!in_ready);
        end
    endtask

    // mostly quick boards, a few costly ones, rare large or oversized ones
    function automatic logic [4:0] random_size();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 88)
                return 5'($urandom_range(9));
            else if (r < 98)
                return 5'($urandom_range(13, 10));
            else
                return 5'($urandom_range(31, 15));
        end
    endfunction

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every size up to the largest, then one that saturates
        for (int i = 0; i <= 16; i++)
            send_size(5'(i));
        send_size(5'd31);

        // random sizes across three idle patterns
        for (int i = 0; i < 100; i++) begin
            if (i == 33) begin
                send_idle = 48;
                recv_idle = 38;
            end
            if (i == 66) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (i == 70)
                hold_go = 1'b1;
            pick = (i >= 70 && i < 74) ? 8 : int'(random_size());
            send_size(5'(pick));
        end
        in_valid <= 1'b0;

        // drain, then watch for stray words
        do
            @(posedge clk);
        while (words_owed != 0);
        repeat (100) @(posedge clk);

        $display("run covered %0d boards (%0d with a placement) and %0d output words",
                 boards_taken, boards_solved, words_taken);
        $display("idle patterns: sender-heavy, receiver-heavy, none; one 400-cycle output hold-off");
        if (mismatches == 0)
            $display("n_queens_backtrack_solver verification clean");
        else
            $display("n_queens_backtrack_solver verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #320_000_000;
        $display("timeout with %0d words still owed", words_owed);
        $display("n_queens_backtrack_solver verification failed");
        $finish;
    end

endmodule
